### src/stc_pkg.sv
// ----------------------------------------------------------------------------
// stc_pkg
// Shared types, constants and helpers for the SMPTE timecode decoder.
// ----------------------------------------------------------------------------
package stc_pkg;

   // Configuration register map
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 40;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE_NUM  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE_DEN  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_LEN = 2'd2;

   localparam int RATE_W = 31;
   localparam int FDUR_W = 40;

   localparam logic [RATE_W-1:0] RATE_NUM_RST  = 31'd30;
   localparam logic [RATE_W-1:0] RATE_DEN_RST  = 31'd1;
   localparam logic [FDUR_W-1:0] FRAME_LEN_RST = 40'd33333333;

   // Rate divider: 32-bit dividend, one quotient bit per cycle
   localparam int DIV_W  = 32;
   localparam int STEP_W = $clog2(DIV_W);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_W - 1);

   // fps / 30 as (fps * ceil(2^36 / 30)) >> 36, exact for any 31-bit rate
   localparam logic [31:0] DIV30_RECIP = 32'd2290649225;
   localparam int          DIV30_SHIFT = 36;

   localparam logic [RATE_W-1:0] DROP_BASE_FPS = 31'd30;
   localparam logic [5:0]        FIELD_FPS     = 6'd50;

   localparam logic [29:0] NS_PER_SEC = 30'd1000000000;

   // Record checks
   localparam logic [4:0]  BYTE_CLIP = 5'd16;
   localparam logic [4:0]  MIN_BYTES = 5'd8;
   localparam logic [31:0] MAX_COUNT = 32'd3;

   // Timecode range limits
   localparam logic [3:0] DIGIT_MAX  = 4'd9;
   localparam logic [6:0] HOUR_MAX   = 7'd23;
   localparam logic [6:0] MINSEC_MAX = 7'd59;
   localparam logic [6:0] FRAME_MAX  = 7'd39;

   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [2:0] {
      CFG_LOAD,
      CFG_DIV_FPS,
      CFG_DIV_30,
      CFG_FINISH,
      CFG_READY
   } cfg_state_type;

   // Values derived from the configuration, stable while transactions flow
   typedef struct packed {
      logic              busy;
      logic              cfg_ok;
      logic              hi_rate;
      logic              is50;
      logic              int_rate;
      logic              drop_ok;
      logic [RATE_W-1:0] fps;
      logic [31:0]       dropn;
      logic [FDUR_W-1:0] fdur;
   } cfg_info_type;

   // One classified record
   typedef struct packed {
      logic       ok;
      logic       drop;
      logic [4:0] hh;
      logic [5:0] mm;
      logic [2:0] mt;
      logic [5:0] ss;
      logic [6:0] ff;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [6:0] bcd_to_bin(input logic [2:0] tens, input logic [3:0] units);
      return ({4'b0000, tens} * 7'd10) + {3'b000, units};
   endfunction

endpackage

### src/stc_cfg.sv
// ----------------------------------------------------------------------------
// stc_cfg
// Configuration registers plus the sequential rate divider that derives
// frames per second and the drop count after every write.
// ----------------------------------------------------------------------------
module stc_cfg (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [stc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [stc_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output stc_pkg::cfg_info_type           cfg_info
);

   stc_pkg::cfg_state_type state_ff, state_in;

   logic [stc_pkg::RATE_W-1:0] num_ff, num_in, den_ff, den_in;
   logic [stc_pkg::FDUR_W-1:0] fdur_ff, fdur_in;

   logic [stc_pkg::STEP_W-1:0] step_ff, step_in;
   logic [stc_pkg::DIV_W-1:0]  rem_ff, rem_in, quo_ff, quo_in;
   logic [stc_pkg::RATE_W-1:0] dvs_ff, dvs_in;

   logic [stc_pkg::RATE_W-1:0] fps_ff, fps_in;
   logic [31:0]                dropn_ff, dropn_in;
   logic drop_ok_ff, drop_ok_in, hi_rate_ff, hi_rate_in, is50_ff, is50_in;
   logic int_rate_ff, int_rate_in, cfg_ok_ff, cfg_ok_in;

   logic [stc_pkg::DIV_W:0]   rem_sh, rem_dif;
   logic                      rem_ge;
   logic [stc_pkg::DIV_W-1:0] rem_nx, quo_nx;
   logic [61:0]               fps_den;
   logic [35:0]               den30;
   logic [36:0]               den50;
   logic [62:0]               fps_recip;
   logic [35:0]               drop_chk;

   assign csr_ready = 1'b1;

   // restoring division step
   assign rem_sh  = {rem_ff, quo_ff[stc_pkg::DIV_W-1]};
   assign rem_dif = rem_sh - {2'b00, dvs_ff};
   assign rem_ge  = rem_sh >= {2'b00, dvs_ff};
   assign rem_nx  = rem_ge ? rem_dif[stc_pkg::DIV_W-1:0] : rem_sh[stc_pkg::DIV_W-1:0];
   assign quo_nx  = {quo_ff[stc_pkg::DIV_W-2:0], rem_ge};

   assign fps_den = {31'd0, fps_ff} * {31'd0, den_ff};
   assign den30   = {5'd0, den_ff} * {5'd0, stc_pkg::DROP_BASE_FPS};
   assign den50   = {6'd0, den_ff} * {31'd0, stc_pkg::FIELD_FPS};

   // fps / 30 by reciprocal; dropn * 15 rebuilds fps when it divides exactly
   assign fps_recip = {32'd0, fps_ff} * {31'd0, stc_pkg::DIV30_RECIP};
   assign drop_chk  = {4'd0, dropn_ff} * 36'd15;

   always_comb begin
      state_in    = state_ff;
      num_in      = num_ff;
      den_in      = den_ff;
      fdur_in     = fdur_ff;
      step_in     = step_ff;
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      dvs_in      = dvs_ff;
      fps_in      = fps_ff;
      dropn_in    = dropn_ff;
      drop_ok_in  = drop_ok_ff;
      hi_rate_in  = hi_rate_ff;
      is50_in     = is50_ff;
      int_rate_in = int_rate_ff;
      cfg_ok_in   = cfg_ok_ff;

      unique case (state_ff)
         stc_pkg::CFG_LOAD: begin
            // round to nearest: (num + den/2) / den
            quo_in   = {1'b0, num_ff} + {2'b00, den_ff[stc_pkg::RATE_W-1:1]};
            rem_in   = '0;
            dvs_in   = den_ff;
            step_in  = '0;
            state_in = stc_pkg::CFG_DIV_FPS;
         end
         stc_pkg::CFG_DIV_FPS: begin
            rem_in  = rem_nx;
            quo_in  = quo_nx;
            step_in = step_ff + stc_pkg::STEP_W'(1);
            if (step_ff == stc_pkg::STEP_LAST) begin
               fps_in   = quo_nx[stc_pkg::RATE_W-1:0];
               step_in  = '0;
               state_in = stc_pkg::CFG_DIV_30;
            end
         end
         stc_pkg::CFG_DIV_30: begin
            dropn_in = {4'd0, fps_recip[62:stc_pkg::DIV30_SHIFT], 1'b0};
            state_in = stc_pkg::CFG_FINISH;
         end
         stc_pkg::CFG_FINISH: begin
            drop_ok_in  = (dropn_ff != '0) && (drop_chk == {5'd0, fps_ff});
            int_rate_in = fps_den == {31'd0, num_ff};
            hi_rate_in  = {5'd0, num_ff} > den30;
            is50_in     = {6'd0, num_ff} == den50;
            cfg_ok_in   = (num_ff != '0) && (den_ff != '0) && (fdur_ff != '0)
                          && (fps_ff != '0);
            state_in    = stc_pkg::CFG_READY;
         end
         stc_pkg::CFG_READY: begin
         end
         default: state_in = stc_pkg::CFG_LOAD;
      endcase

      // any write restarts the derivation
      if (csr_valid) begin
         unique case (csr_index)
            stc_pkg::CSR_RATE_NUM:  num_in  = csr_wdata[stc_pkg::RATE_W-1:0];
            stc_pkg::CSR_RATE_DEN:  den_in  = csr_wdata[stc_pkg::RATE_W-1:0];
            stc_pkg::CSR_FRAME_LEN: fdur_in = csr_wdata[stc_pkg::FDUR_W-1:0];
            default: begin
            end
         endcase
         state_in = stc_pkg::CFG_LOAD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= stc_pkg::CFG_LOAD;
         step_ff  <= '0;
         num_ff   <= stc_pkg::RATE_NUM_RST;
         den_ff   <= stc_pkg::RATE_DEN_RST;
         fdur_ff  <= stc_pkg::FRAME_LEN_RST;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         num_ff   <= num_in;
         den_ff   <= den_in;
         fdur_ff  <= fdur_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      dvs_ff      <= dvs_in;
      fps_ff      <= fps_in;
      dropn_ff    <= dropn_in;
      drop_ok_ff  <= drop_ok_in;
      hi_rate_ff  <= hi_rate_in;
      is50_ff     <= is50_in;
      int_rate_ff <= int_rate_in;
      cfg_ok_ff   <= cfg_ok_in;
   end

   assign cfg_info.busy     = state_ff != stc_pkg::CFG_READY;
   assign cfg_info.cfg_ok   = cfg_ok_ff;
   assign cfg_info.hi_rate  = hi_rate_ff;
   assign cfg_info.is50     = is50_ff;
   assign cfg_info.int_rate = int_rate_ff;
   assign cfg_info.drop_ok  = drop_ok_ff;
   assign cfg_info.fps      = fps_ff;
   assign cfg_info.dropn    = dropn_ff;
   assign cfg_info.fdur     = fdur_ff;

endmodule

### src/stc_front.sv
// ----------------------------------------------------------------------------
// stc_front
// Record and timecode checks; unpacks the BCD fields into a queue entry.
// ----------------------------------------------------------------------------
module stc_front (
   input  logic [4:0]            req_byte_count,
   input  logic [31:0]           req_word_count,
   input  logic [31:0]           req_timecode_word,
   input  stc_pkg::cfg_info_type cfg_info,
   output stc_pkg::item_type     entry
);

   logic [4:0]  size_c, need;
   logic        cnt_ok, rec_ok, digits_ok, range_ok, fld, ff_ok, skip, drop_bad;
   logic [6:0]  hh_v, mm_v, ss_v, ff_v, ff_x;
   logic [31:0] tc;

   assign tc = req_timecode_word;

   always_comb begin
      size_c = (req_byte_count > stc_pkg::BYTE_CLIP) ? stc_pkg::BYTE_CLIP : req_byte_count;
      cnt_ok = (req_word_count != 32'd0) && (req_word_count <= stc_pkg::MAX_COUNT);
      need   = ({3'b000, req_word_count[1:0]} + 5'd1) << 2;
      rec_ok = (size_c >= stc_pkg::MIN_BYTES) && cnt_ok && (size_c >= need);

      // hours 5:0, minutes 14:8, seconds 22:16, frames 29:24
      hh_v = stc_pkg::bcd_to_bin({1'b0, tc[5:4]}, tc[3:0]);
      mm_v = stc_pkg::bcd_to_bin(tc[14:12], tc[11:8]);
      ss_v = stc_pkg::bcd_to_bin(tc[22:20], tc[19:16]);
      ff_v = stc_pkg::bcd_to_bin({1'b0, tc[29:28]}, tc[27:24]);

      digits_ok = (tc[3:0] <= stc_pkg::DIGIT_MAX) && (tc[11:8] <= stc_pkg::DIGIT_MAX)
                  && (tc[19:16] <= stc_pkg::DIGIT_MAX) && (tc[27:24] <= stc_pkg::DIGIT_MAX);
      range_ok  = (hh_v <= stc_pkg::HOUR_MAX) && (mm_v <= stc_pkg::MINSEC_MAX)
                  && (ss_v <= stc_pkg::MINSEC_MAX) && (ff_v <= stc_pkg::FRAME_MAX);

      // field bit sits in bit 7 at exactly 50 fps, bit 23 otherwise
      fld   = cfg_info.is50 ? tc[7] : tc[23];
      ff_x  = cfg_info.hi_rate ? {ff_v[5:0], fld} : ff_v;
      ff_ok = {24'd0, ff_x} < cfg_info.fps;

      // skipped label: frame < dropn at second 0, minute not a multiple of ten
      skip     = (ss_v == 7'd0) && (tc[11:8] != 4'd0) && ({25'd0, ff_x} < cfg_info.dropn);
      drop_bad = tc[30] && (!cfg_info.drop_ok || skip);

      entry.ok   = rec_ok && cfg_info.cfg_ok && digits_ok && range_ok && ff_ok && !drop_bad;
      entry.drop = tc[30];
      entry.hh   = hh_v[4:0];
      entry.mm   = mm_v[5:0];
      entry.mt   = tc[14:12];
      entry.ss   = ss_v[5:0];
      entry.ff   = ff_x;
   end

endmodule

### src/stc_queue.sv
// ----------------------------------------------------------------------------
// stc_queue
// Small FIFO between the classifying front and the arithmetic back end.
// ----------------------------------------------------------------------------
module stc_queue #(
   parameter int DEPTH = stc_pkg::QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  stc_pkg::item_type         push_item,
   input  logic                      pop,
   output stc_pkg::item_type         pop_item,
   output stc_pkg::queue_status_type status
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   stc_pkg::item_type mem_ff [DEPTH];

   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
      unique case ({push, pop})
         2'b10:   cnt_in = cnt_ff + CNT_W'(1);
         2'b01:   cnt_in = cnt_ff - CNT_W'(1);
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

   assign pop_item     = mem_ff[rd_ff];
   assign status.full  = cnt_ff == CNT_W'(DEPTH);
   assign status.empty = cnt_ff == '0;

endmodule

### src/stc_back.sv
// ----------------------------------------------------------------------------
// stc_back
// Arithmetic pipeline: frame count, drop correction and the 64-bit
// nanosecond product built from 32x20 partial products.
// ----------------------------------------------------------------------------
module stc_back (
   input  logic                  clock,
   input  logic                  reset,
   input  stc_pkg::cfg_info_type cfg_info,
   input  stc_pkg::item_type     head,
   input  logic                  head_valid,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_valid_res,
   output logic [63:0]           rsp_timestamp
);

   logic adv;

   // stage 1: seconds and dropped-minute count
   logic        v1_ff, ok1_ff, drop1_ff;
   logic [16:0] secs1_ff, secs1_in;
   logic [10:0] tm1_ff, tm1_in, tmin;
   logic [6:0]  ff1_ff;
   // stage 2: frame count, drop subtrahend, whole-second ns
   logic        v2_ff, ok2_ff, drop2_ff;
   logic [47:0] cnt2_ff, cnt2_in;
   logic [31:0] sub2_ff, sub2_in;
   logic [46:0] sns2_ff, sns2_in;
   logic [6:0]  ff2_ff;
   // stage 3: multiplicand and addend
   logic        v3_ff, ok3_ff;
   logic [63:0] x3_ff, x3_in, y3_ff, y3_in;
   // stage 4: low partial products
   logic        v4_ff, ok4_ff;
   logic [51:0] pp0_ff, pp0_in, pp1_ff, pp1_in;
   logic [31:0] xhi4_ff;
   logic [63:0] y4_ff;
   // stage 5: high partial products and partial sum
   logic        v5_ff, ok5_ff;
   logic [63:0] s5_ff, s5_in;
   logic [31:0] pp2_ff, pp2_in;
   logic [11:0] pp3_ff, pp3_in;
   // output register
   logic        vo_ff, oko_ff;
   logic [63:0] ts_ff, ts_in;

   assign adv = !vo_ff || rsp_ready;
   assign pop = adv && head_valid;

   always_comb begin
      tmin     = ({6'd0, head.hh} * 11'd60) + {5'd0, head.mm};
      secs1_in = ({6'd0, tmin} * 17'd60) + {11'd0, head.ss};
      // minutes less the tens of minutes: hh*54 + mm - minute tens
      tm1_in   = ({6'd0, head.hh} * 11'd54) + {5'd0, head.mm} - {8'd0, head.mt};

      cnt2_in = ({31'd0, secs1_ff} * {17'd0, cfg_info.fps}) + {41'd0, ff1_ff};
      sub2_in = {21'd0, tm1_ff} * cfg_info.dropn;
      sns2_in = {30'd0, secs1_ff} * {17'd0, stc_pkg::NS_PER_SEC};

      priority if (drop2_ff) begin
         x3_in = {16'd0, cnt2_ff} - {32'd0, sub2_ff};
         y3_in = '0;
      end else if (!cfg_info.int_rate) begin
         x3_in = {16'd0, cnt2_ff};
         y3_in = '0;
      end else begin
         x3_in = {57'd0, ff2_ff};
         y3_in = {17'd0, sns2_ff};
      end

      pp0_in = {20'd0, x3_ff[31:0]} * {32'd0, cfg_info.fdur[19:0]};
      pp1_in = {20'd0, x3_ff[31:0]} * {32'd0, cfg_info.fdur[39:20]};

      s5_in  = y4_ff + {12'd0, pp0_ff} + {pp1_ff[43:0], 20'd0};
      pp2_in = xhi4_ff * {12'd0, cfg_info.fdur[19:0]};
      pp3_in = xhi4_ff[11:0] * cfg_info.fdur[31:20];

      ts_in = s5_ff + {pp2_ff, 32'd0} + {pp3_ff, 52'd0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= head_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         vo_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ok1_ff   <= head.ok;
         drop1_ff <= head.drop;
         secs1_ff <= secs1_in;
         tm1_ff   <= tm1_in;
         ff1_ff   <= head.ff;

         ok2_ff   <= ok1_ff;
         drop2_ff <= drop1_ff;
         cnt2_ff  <= cnt2_in;
         sub2_ff  <= sub2_in;
         sns2_ff  <= sns2_in;
         ff2_ff   <= ff1_ff;

         ok3_ff   <= ok2_ff;
         x3_ff    <= x3_in;
         y3_ff    <= y3_in;

         ok4_ff   <= ok3_ff;
         pp0_ff   <= pp0_in;
         pp1_ff   <= pp1_in;
         xhi4_ff  <= x3_ff[63:32];
         y4_ff    <= y3_ff;

         ok5_ff   <= ok4_ff;
         s5_ff    <= s5_in;
         pp2_ff   <= pp2_in;
         pp3_ff   <= pp3_in;

         oko_ff   <= ok5_ff;
         ts_ff    <= ok5_ff ? ts_in : '0;
      end
   end

   assign rsp_valid     = vo_ff;
   assign rsp_valid_res = oko_ff;
   assign rsp_timestamp = ts_ff;

endmodule

### src/smpte_timecode_to_timestamp.sv
// ----------------------------------------------------------------------------
// smpte_timecode_to_timestamp
// SMPTE 12M timecode side-data record to nanosecond timestamp decoder.
// ----------------------------------------------------------------------------
// Takes one record per cycle while req_ready is high and returns one result
// per record, in order. The front checks the record and the BCD timecode;
// a short queue decouples it from a six-register arithmetic pipeline
// (frame count, drop-frame correction, then the 64-bit product with the
// frame length in 32x20 partial products). After reset and after every
// configuration write, req_ready stays low while a one-bit-per-cycle
// divider derives frames per second (one 32-step division), a reciprocal
// multiply gives the drop count and the rate flags are settled. Results of
// failed checks carry valid_res low and a zero timestamp.
// ----------------------------------------------------------------------------
module smpte_timecode_to_timestamp #(
   parameter int QUEUE_DEPTH = stc_pkg::QUEUE_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   // record transactions
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [4:0]                     req_byte_count,
   input  logic [31:0]                    req_word_count,
   input  logic [31:0]                    req_timecode_word,
   // result transactions
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_valid_res,
   output logic signed [63:0]             rsp_timestamp_ns,
   // configuration writes
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [stc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [stc_pkg::CSR_DATA_W-1:0] csr_wdata
);

   stc_pkg::cfg_info_type     cfg_info;
   stc_pkg::item_type         front_item, head_item;
   stc_pkg::queue_status_type q_status;
   logic                      q_push, q_pop;
   logic [63:0]               ts_raw;

   // Config registers and derived rate values
   stc_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg_info  (cfg_info)
   );

   // Front: classify the record as it arrives
   stc_front u_front (
      .req_byte_count    (req_byte_count),
      .req_word_count    (req_word_count),
      .req_timecode_word (req_timecode_word),
      .cfg_info          (cfg_info),
      .entry             (front_item)
   );

   // Intake is held while the divider works or the queue is full
   assign req_ready = !cfg_info.busy && !q_status.full;
   assign q_push    = req_valid && req_ready;

   stc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (front_item),
      .pop       (q_pop),
      .pop_item  (head_item),
      .status    (q_status)
   );

   // Back end: pops whenever its pipeline can move
   stc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg_info      (cfg_info),
      .head          (head_item),
      .head_valid    (!q_status.empty),
      .pop           (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_valid_res (rsp_valid_res),
      .rsp_timestamp (ts_raw)
   );

   assign rsp_timestamp_ns = $signed(ts_raw);

`ifndef SYNTHESIS
   // a config write must block intake until the rates are re-derived
   a_cfg_blocks: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |=> !req_ready)
      else $error("record accepted straight after a config write");

   // rates are derived after reset before any record is taken
   a_reset_blocks: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ready)
      else $error("record accepted before rate derivation");

   // never push into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_status.full)
      else $error("queue overflow");

   // failed records carry a zero timestamp
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_valid_res |-> rsp_timestamp_ns == 64'sd0)
      else $error("invalid result with nonzero timestamp");
`endif

endmodule

### tb/sv/smpte_timecode_to_timestamp_tb.sv
// ----------------------------------------------------------------------------
// smpte_timecode_to_timestamp_tb
// Self-checking bench for the SMPTE 12M timecode to timestamp decoder.
// Drives record transactions and register writes, predicts every result
// from its own copy of the rate settings and checks results in order,
// with random bursts on the request side and stalls on the result side.
// ----------------------------------------------------------------------------
module smpte_timecode_to_timestamp_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam time CLK_HALF       = 4ns;
   localparam int  RESET_CYCLES   = 7;
   localparam int  QUIET_LIMIT    = 5000;  // cycles with no transaction at all
   localparam int  TAIL_CYCLES    = 16;    // idle cycles after the final drain
   localparam int  NS_PER_SECOND  = 1000000000;

   typedef struct packed {
      logic [4:0]  byte_count;
      logic [31:0] word_count;
      logic [31:0] timecode_word;
   } tc_record_type;

   typedef struct packed {
      logic        valid_res;
      logic [63:0] timestamp_ns;
   } stamp_type;

   // ---------------------------------------------------------------------
   // Clock, reset and block inputs (all known from time zero)
   // ---------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                           req_valid         = 1'b0;
   logic                           req_ready;
   logic [4:0]                     req_byte_count    = '0;
   logic [31:0]                    req_word_count    = '0;
   logic [31:0]                    req_timecode_word = '0;
   logic                           rsp_valid;
   logic                           rsp_ready         = 1'b1;
   logic                           rsp_valid_res;
   logic signed [63:0]             rsp_timestamp_ns;
   logic                           csr_valid         = 1'b0;
   logic                           csr_ready;
   logic [stc_pkg::CSR_IDX_W-1:0]  csr_index         = '0;
   logic [stc_pkg::CSR_DATA_W-1:0] csr_wdata         = '0;

   always begin
      #(CLK_HALF) clock = 1'b1;
      #(CLK_HALF) clock = 1'b0;
   end

   smpte_timecode_to_timestamp uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_byte_count    (req_byte_count),
      .req_word_count    (req_word_count),
      .req_timecode_word (req_timecode_word),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_valid_res     (rsp_valid_res),
      .rsp_timestamp_ns  (rsp_timestamp_ns),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // ---------------------------------------------------------------------
   // Predictor: own copy of the rate settings, held 64 bits wide so that
   // the products below wrap exactly as the block's 64-bit datapath does.
   // ---------------------------------------------------------------------
   logic [63:0] cfg_rate_num  = 64'(stc_pkg::RATE_NUM_RST);
   logic [63:0] cfg_rate_den  = 64'(stc_pkg::RATE_DEN_RST);
   logic [63:0] cfg_frame_len = 64'(stc_pkg::FRAME_LEN_RST);

   stamp_type   stamps_due[$];   // one entry per accepted record, oldest first
   int          mismatch_count = 0;
   int unsigned burst_left     = 0;

   // Frames per second: rate rounded to nearest, halves up
   function automatic logic [63:0] rate_fps();
      if (cfg_rate_den == 0)
         return 64'd0;
      return (cfg_rate_num + cfg_rate_den / 2) / cfg_rate_den;
   endfunction

   // Two BCD digits; false on a digit above nine or a value above top
   function automatic bit bcd_field(input logic [3:0] tens, input logic [3:0] units,
                                    input int unsigned top, output int unsigned val);
      val = 32'(tens) * 32'd10 + 32'(units);
      return tens <= 4'd9 && units <= 4'd9 && val <= top;
   endfunction

   function automatic stamp_type decode_stamp(input tc_record_type rec);
      stamp_type   res;
      logic [63:0] rec_size, fps, secs, frame_total;
      logic [31:0] tc;
      int unsigned hh, mm, ss, ff, dropn, tmin, dropped;
      res.valid_res    = 1'b0;
      res.timestamp_ns = 64'd0;
      tc               = rec.timecode_word;
      rec_size         = (rec.byte_count > 5'd16) ? 64'd16 : 64'(rec.byte_count);

      // record framing
      if (rec_size < 64'd8 || rec.word_count == 32'd0 || rec.word_count > 32'd3 ||
          rec_size < 64'd4 * (64'(rec.word_count) + 64'd1))
         return res;
      if (cfg_rate_num == 0 || cfg_rate_den == 0 || cfg_frame_len == 0)
         return res;
      fps = rate_fps();
      if (fps == 0)
         return res;

      if (!bcd_field({2'b00, tc[5:4]}, tc[3:0], 23, hh) ||
          !bcd_field({1'b0, tc[14:12]}, tc[11:8], 59, mm) ||
          !bcd_field({1'b0, tc[22:20]}, tc[19:16], 59, ss) ||
          !bcd_field({2'b00, tc[29:28]}, tc[27:24], 39, ff))
         return res;

      // above 30 fps the frame number counts field pairs
      if (cfg_rate_num > 64'd30 * cfg_rate_den)
         ff = ff * 2 + ((cfg_rate_num == 64'd50 * cfg_rate_den) ? tc[7] : tc[23]);
      if (64'(ff) >= fps)
         return res;

      secs        = (64'(hh) * 60 + 64'(mm)) * 60 + 64'(ss);
      frame_total = secs * fps + 64'(ff);
      if (tc[30]) begin
         // drop frame: counts repeat per 30 fps, skipped numbers are illegal
         dropn = 32'(fps / 30 * 2);
         tmin  = hh * 60 + mm;
         if (dropn == 0 || fps % 30 != 0)
            return res;
         if (ss == 0 && mm % 10 != 0 && ff < dropn)
            return res;
         dropped          = dropn * (tmin - tmin / 10);   // 32-bit wrap
         res.timestamp_ns = (frame_total - 64'(dropped)) * cfg_frame_len;
      end else if (cfg_rate_num != fps * cfg_rate_den) begin
         res.timestamp_ns = frame_total * cfg_frame_len;
      end else begin
         res.timestamp_ns = secs * 64'(NS_PER_SECOND) + 64'(ff) * cfg_frame_len;
      end
      res.valid_res = 1'b1;
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus source: mostly well-formed records with random content,
   // the rest broken framing or raw random timecode words.
   // ---------------------------------------------------------------------
   function automatic tc_record_type random_record();
      tc_record_type rec;
      int unsigned   pick, hh, mm, ss, ff, lim, min_bytes;
      logic [63:0]   fps;
      pick            = $urandom_range(0, 99);
      rec.word_count  = $urandom_range(1, 3);
      min_bytes       = (rec.word_count == 1) ? 8 : 4 * (rec.word_count + 1);
      rec.byte_count  = 5'($urandom_range(min_bytes, 16));
      rec.timecode_word = $urandom;
      if (pick < 15) begin
         rec.byte_count = 5'($urandom_range(0, 16));
         rec.word_count = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 5) : $urandom;
      end
      if (pick >= 25) begin
         // legal BCD fields; spare, field and drop bits stay random
         fps = rate_fps();
         if (cfg_rate_num > 64'd30 * cfg_rate_den)
            fps = fps / 2;
         lim = (fps > 40) ? 40 : ((fps == 0) ? 1 : int'(fps));
         hh  = $urandom_range(0, 23);
         mm  = $urandom_range(0, 59);
         ss  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 59);
         ff  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 39) : $urandom_range(0, lim - 1);
         if ($urandom_range(0, 3) == 0)
            ff = $urandom_range(0, (lim > 8) ? 7 : lim - 1);
         rec.timecode_word[5:0]   = {2'(hh / 10), 4'(hh % 10)};
         rec.timecode_word[14:8]  = {3'(mm / 10), 4'(mm % 10)};
         rec.timecode_word[22:16] = {3'(ss / 10), 4'(ss % 10)};
         rec.timecode_word[29:24] = {2'(ff / 10), 4'(ff % 10)};
      end
      return rec;
   endfunction

   // One record transaction. Valid stays high across a burst; a gap drops
   // it for a random number of cycles before the next burst starts.
   task automatic send_record(input logic [4:0] byte_count, input logic [31:0] word_count,
                              input logic [31:0] timecode_word);
      tc_record_type rec;
      int unsigned   gap;
      rec = {byte_count, word_count, timecode_word};
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if ($urandom_range(0, 9) == 0)
            gap = $urandom_range(10, 16);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_valid         <= 1'b1;
      req_byte_count    <= rec.byte_count;
      req_word_count    <= rec.word_count;
      req_timecode_word <= rec.timecode_word;
      do @(posedge clock); while (!req_ready);
      stamps_due.push_back(decode_stamp(rec));
   endtask

   // Stop sending and wait until every outstanding transaction has returned
   task automatic drain();
      req_valid  <= 1'b0;
      burst_left  = 0;
      do @(posedge clock); while (stamps_due.size() != 0);
   endtask

   task automatic write_csr(input logic [stc_pkg::CSR_IDX_W-1:0] idx,
                            input logic [stc_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         stc_pkg::CSR_RATE_NUM:  cfg_rate_num  = 64'(data[stc_pkg::RATE_W-1:0]);
         stc_pkg::CSR_RATE_DEN:  cfg_rate_den  = 64'(data[stc_pkg::RATE_W-1:0]);
         stc_pkg::CSR_FRAME_LEN: cfg_frame_len = 64'(data[stc_pkg::FDUR_W-1:0]);
         default: ;
      endcase
   endtask

   // New rate setting, only once the block has gone idle; csr_valid is held
   // across the three writes and dropped after the last one.
   task automatic apply_rate(input logic [30:0] num, input logic [30:0] den,
                             input logic [39:0] frame_len);
      drain();
      write_csr(stc_pkg::CSR_RATE_NUM, 40'(num));
      write_csr(stc_pkg::CSR_RATE_DEN, 40'(den));
      write_csr(stc_pkg::CSR_FRAME_LEN, frame_len);
      csr_valid <= 1'b0;
   endtask

   task automatic run_rate_phase(input logic [30:0] num, input logic [30:0] den,
                                 input logic [39:0] frame_len, input int n_records);
      tc_record_type rec;
      apply_rate(num, den, frame_len);
      repeat (n_records) begin
         rec = random_record();
         send_record(rec.byte_count, rec.word_count, rec.timecode_word);
      end
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Size and count checks at the reset rate; timecode 01:02:03:04
   task automatic test_record_checks();
      send_record(5'd0,  32'd1, 32'h0403_0201);
      send_record(5'd7,  32'd1, 32'h0403_0201);   // one byte short
      send_record(5'd8,  32'd1, 32'h0403_0201);   // smallest legal record
      send_record(5'd8,  32'd2, 32'h0403_0201);   // too short for two words
      send_record(5'd12, 32'd3, 32'h0403_0201);   // too short for three words
      send_record(5'd16, 32'd3, 32'h0403_0201);
      send_record(5'd16, 32'd0, 32'h0403_0201);   // count below range
      send_record(5'd16, 32'd4, 32'h0403_0201);   // count above range
      send_record(5'd16, 32'hFFFF_FFFF, 32'h0403_0201);
   endtask

   // Digit and range checks, frame limit and drop-frame skipping at 30 fps
   task automatic test_timecode_fields();
      send_record(5'd16, 32'd1, 32'h0000_0000);
      send_record(5'd16, 32'd1, 32'h2959_5923);   // 23:59:59:29
      send_record(5'd16, 32'd1, 32'h0000_000A);   // hour digit
      send_record(5'd16, 32'd1, 32'h0000_0024);   // hour range
      send_record(5'd16, 32'd1, 32'h0000_0030);   // hour tens past range
      send_record(5'd16, 32'd1, 32'h0000_6000);   // minute range
      send_record(5'd16, 32'd1, 32'h0000_0F00);   // minute digit
      send_record(5'd16, 32'd1, 32'h0060_0000);   // second range
      send_record(5'd16, 32'd1, 32'h000A_0000);   // second digit
      send_record(5'd16, 32'd1, 32'h0A00_0000);   // frame digit
      send_record(5'd16, 32'd1, 32'h3900_0000);   // frame at top of BCD range
      send_record(5'd16, 32'd1, 32'h3000_0000);   // frame equal to fps
      send_record(5'd16, 32'd1, 32'h4000_0100);   // skipped number 00:01:00;00
      send_record(5'd16, 32'd1, 32'h4200_0100);   // first kept number 00:01:00;02
      send_record(5'd16, 32'd1, 32'h4000_1000);   // tenth minute keeps frame 0
      send_record(5'd16, 32'd1, 32'h6959_5923);   // drop frame 23:59:59;29
      send_record(5'd16, 32'd1, 32'h8080_80C0);   // spare and field bits ignored
      send_record(5'd16, 32'd1, 32'hFFFF_FFFF);
   endtask

   // Common rates: fractional, halves rounding up, field bits, drop multiples
   task automatic test_frame_rates();
      run_rate_phase(31'd30000, 31'd1001, 40'd33366667, 30);
      run_rate_phase(31'd25,    31'd1,    40'd40000000, 30);   // drop illegal
      run_rate_phase(31'd24,    31'd1,    40'd41666667, 30);
      run_rate_phase(31'd45,    31'd2,    40'd44444444, 30);   // 22.5 rounds to 23
      run_rate_phase(31'd50,    31'd1,    40'd20000000, 30);   // field in bit 7
      run_rate_phase(31'd60000, 31'd1001, 40'd16683333, 30);   // field in bit 23
      run_rate_phase(31'd60,    31'd1,    40'd16666667, 30);
      run_rate_phase(31'd120,   31'd1,    40'd8333333,  30);
      run_rate_phase(31'd31,    31'd1,    40'd32258065, 30);   // just above 30 fps
   endtask

   // Zero settings, rates rounding to zero or one, and wrapping arithmetic
   task automatic test_degenerate_rates();
      run_rate_phase(31'd0,          31'd1,          40'd33333333,      10);
      run_rate_phase(31'd30,         31'd0,          40'd33333333,      10);
      run_rate_phase(31'd30,         31'd1,          40'd0,             10);
      run_rate_phase(31'd1,          31'h7FFF_FFFF,  40'd1000,          10);
      run_rate_phase(31'h7FFF_FFFF,  31'h7FFF_FFFF,  40'hFF_FFFF_FFFF,  10);
      run_rate_phase(31'h4000_0000,  31'h7FFF_FFFF,  40'd1,             10);
      // largest multiple of 30: drop product and timestamp both wrap
      run_rate_phase(31'd2147483640, 31'd1,          40'hFF_FFFF_FFFF,  10);
      run_rate_phase(31'h7FFF_FFFF,  31'd1,          40'hFF_FFFF_FFFF,  10);
   endtask

   task automatic test_random_rates();
      int unsigned fps, den, num, frame_len_lo;
      logic [39:0] frame_len;
      repeat (8) begin
         case ($urandom_range(0, 3))
            0: fps = 24;
            1: fps = 30 * $urandom_range(1, 8);
            2: fps = 50;
            default: fps = $urandom_range(1, 300);
         endcase
         case ($urandom_range(0, 3))
            0: begin den = 1; num = fps; end
            1: begin den = 1001; num = fps * 1000; end
            2: begin den = $urandom_range(1, 4000); num = fps * den + $urandom_range(0, den); end
            default: begin num = $urandom_range(0, 32'h7FFF_FFFF);
                           den = $urandom_range(0, 32'h7FFF_FFFF); end
         endcase
         frame_len_lo = NS_PER_SECOND / fps;
         frame_len    = ($urandom_range(0, 3) == 0) ? {8'($urandom), 32'($urandom)}
                                                     : 40'(frame_len_lo);
         run_rate_phase(31'(num), 31'(den), frame_len, 30);
      end
   endtask

   // ---------------------------------------------------------------------
   // Result checking: every result against the oldest expectation
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      stamp_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (stamps_due.size() == 0) begin
            $error("result with no transaction outstanding: valid_res %0b timestamp_ns %0d",
                   rsp_valid_res, rsp_timestamp_ns);
            mismatch_count++;
         end else begin
            due = stamps_due.pop_front();
            if (rsp_valid_res !== due.valid_res) begin
               $error("valid_res mismatch: expected %0b, actual %0b",
                      due.valid_res, rsp_valid_res);
               mismatch_count++;
            end
            if (rsp_timestamp_ns !== due.timestamp_ns) begin
               $error("timestamp_ns mismatch: expected %0d, actual %0d",
                      $signed(due.timestamp_ns), rsp_timestamp_ns);
               mismatch_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result-side back-pressure: long stretches always ready, alternating
   // with stretches of random ready/stall runs.
   // ---------------------------------------------------------------------
   int unsigned style_left = 0;
   int unsigned run_left   = 0;
   bit          stalling   = 1'b0;

   always @(posedge clock) begin
      if (style_left == 0) begin
         stalling   = $urandom_range(0, 2) != 0;
         style_left = $urandom_range(50, 300);
      end
      style_left--;
      if (!stalling) begin
         rsp_ready <= 1'b1;
      end else if (run_left == 0) begin
         rsp_ready <= !rsp_ready;
         run_left   = rsp_ready ? $urandom_range(1, 12) : $urandom_range(1, 6);
      end else begin
         run_left--;
      end
   end

   // ---------------------------------------------------------------------
   // Watchdog: too long without any transaction on any channel
   // ---------------------------------------------------------------------
   int unsigned quiet_cycles = 0;

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("smpte_timecode_to_timestamp_tb: FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_record_checks();
      test_timecode_fields();
      test_frame_rates();
      test_degenerate_rates();
      test_random_rates();

      // everything returned, then a short tail to catch stray results
      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("smpte_timecode_to_timestamp_tb: PASS");
      else
         $display("smpte_timecode_to_timestamp_tb: FAIL");
      $finish;
   end

endmodule
